/* rtl/hbp_pkg.sv */
// Shared types, constants and helpers of the tournament branch predictor.
`default_nettype none

package hbp_pkg;

  localparam int unsigned GSHARE_INDEX_BITS  = 10;
  localparam int unsigned HISTORY_BITS       = 8;
  localparam int unsigned BIMODAL_INDEX_BITS = 10;
  localparam int unsigned CHOOSER_INDEX_BITS = 10;

  // History bits that take part in the gshare index.
  localparam int unsigned HIST_USED = (HISTORY_BITS < GSHARE_INDEX_BITS) ?
                                      HISTORY_BITS : GSHARE_INDEX_BITS;
  localparam int unsigned HIST_W    = (HIST_USED > 0) ? HIST_USED : 1;

  // Index width of the clearing sweep: the deepest table.
  localparam int unsigned CLR_BITS_A = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                                       GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int unsigned CLR_BITS   = (CLR_BITS_A > CHOOSER_INDEX_BITS) ?
                                       CLR_BITS_A : CHOOSER_INDEX_BITS;

  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  localparam logic [1:0] CTR_MIN          = 2'd0;
  localparam logic [1:0] CTR_WEAK_BIMODAL = 2'd1;
  localparam logic [1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [1:0] CTR_MAX          = 2'd3;

  typedef logic [1:0]                    ctr_t;
  typedef logic [GSHARE_INDEX_BITS-1:0]  gs_idx_t;
  typedef logic [BIMODAL_INDEX_BITS-1:0] bi_idx_t;
  typedef logic [CHOOSER_INDEX_BITS-1:0] ch_idx_t;
  typedef logic [HIST_W-1:0]             hist_t;
  typedef logic [CLR_BITS-1:0]           clr_idx_t;

  typedef struct packed {
    logic    en;
    bi_idx_t bi_idx;
    gs_idx_t gs_idx;
    ch_idx_t ch_idx;
  } rd_req_t;

  typedef struct packed {
    logic bi_we;
    logic gs_we;
    logic ch_we;
    ctr_t bi_ctr;
    ctr_t gs_ctr;
    ctr_t ch_ctr;
  } wr_req_t;

  typedef struct packed {
    ctr_t bc;
    ctr_t gc;
    ctr_t cc;
  } ctr_rd_t;

  // Two-bit saturating counter step.
  function automatic ctr_t sat_train(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hbp_intf.sv */
// Valid/ready channel interfaces for branch items and prediction results.
`default_nettype none

interface hbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_pc;
  logic        taken;

  modport source (output valid, output branch_pc, output taken, input ready);
  modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface hbp_out_if;
  logic        valid;
  logic        ready;
  logic        predicted_taken;
  logic        mispredicted;
  logic        used_gshare;
  logic [31:0] mispredict_total;

  modport source (output valid, output predicted_taken, output mispredicted,
                  output used_gshare, output mispredict_total, input ready);
  modport sink   (input valid, input predicted_taken, input mispredicted,
                  input used_gshare, input mispredict_total, output ready);
endinterface

`default_nettype wire

/* rtl/hbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/hbp_tables.sv */
// Counter tables: three RAMs, clearing sweep and write-to-read bypass.
`default_nettype none

module hbp_tables import hbp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire rd_req_t rd_i,
  input  wire wr_req_t wr_i,
  output ctr_rd_t      ctr_o,
  output logic         busy_o
);

  bi_idx_t  bi_idx_q;
  gs_idx_t  gs_idx_q;
  ch_idx_t  ch_idx_q;

  logic     clr_busy_q;
  clr_idx_t clr_idx_q;

  logic     bi_byp_vld_q, gs_byp_vld_q, ch_byp_vld_q;
  bi_idx_t  bi_byp_idx_q;
  gs_idx_t  gs_byp_idx_q;
  ch_idx_t  ch_byp_idx_q;
  ctr_t     bi_byp_q, gs_byp_q, ch_byp_q;

  logic     bi_we, gs_we, ch_we;
  bi_idx_t  bi_waddr;
  gs_idx_t  gs_waddr;
  ch_idx_t  ch_waddr;
  ctr_t     bi_wdata, gs_wdata, ch_wdata;
  ctr_t     bi_rdata, gs_rdata, ch_rdata;

  // Sweep the reset values in first, then take the pipeline's writes.
  always_comb begin
    bi_we    = clr_busy_q | wr_i.bi_we;
    gs_we    = clr_busy_q | wr_i.gs_we;
    ch_we    = clr_busy_q | wr_i.ch_we;
    bi_waddr = clr_busy_q ? clr_idx_q[BIMODAL_INDEX_BITS-1:0] : bi_idx_q;
    gs_waddr = clr_busy_q ? clr_idx_q[GSHARE_INDEX_BITS-1:0]  : gs_idx_q;
    ch_waddr = clr_busy_q ? clr_idx_q[CHOOSER_INDEX_BITS-1:0] : ch_idx_q;
    bi_wdata = clr_busy_q ? CTR_WEAK_TAKEN   : wr_i.bi_ctr;
    gs_wdata = clr_busy_q ? CTR_WEAK_TAKEN   : wr_i.gs_ctr;
    ch_wdata = clr_busy_q ? CTR_WEAK_BIMODAL : wr_i.ch_ctr;
  end

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** BIMODAL_INDEX_BITS)) u_bi_ram (
    .clk_i   (clk_i),
    .we_i    (bi_we),
    .waddr_i (bi_waddr),
    .wdata_i (bi_wdata),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.bi_idx),
    .rdata_o (bi_rdata)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** GSHARE_INDEX_BITS)) u_gs_ram (
    .clk_i   (clk_i),
    .we_i    (gs_we),
    .waddr_i (gs_waddr),
    .wdata_i (gs_wdata),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.gs_idx),
    .rdata_o (gs_rdata)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** CHOOSER_INDEX_BITS)) u_ch_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.ch_idx),
    .rdata_o (ch_rdata)
  );

  // Hold the indices of the item under update; they also address its write.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      bi_idx_q <= rd_i.bi_idx;
      gs_idx_q <= rd_i.gs_idx;
      ch_idx_q <= rd_i.ch_idx;
    end
    if (wr_i.bi_we) begin
      bi_byp_idx_q <= bi_idx_q;
      bi_byp_q     <= wr_i.bi_ctr;
    end
    if (wr_i.gs_we) begin
      gs_byp_idx_q <= gs_idx_q;
      gs_byp_q     <= wr_i.gs_ctr;
    end
    if (wr_i.ch_we) begin
      ch_byp_idx_q <= ch_idx_q;
      ch_byp_q     <= wr_i.ch_ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q   <= 1'b1;
      clr_idx_q    <= '0;
      bi_byp_vld_q <= 1'b0;
      gs_byp_vld_q <= 1'b0;
      ch_byp_vld_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_t'(clr_idx_q + 1'b1);
        if (clr_idx_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (wr_i.bi_we) bi_byp_vld_q <= 1'b1;
      if (wr_i.gs_we) gs_byp_vld_q <= 1'b1;
      if (wr_i.ch_we) ch_byp_vld_q <= 1'b1;
    end
  end

  // The latest write lands on the same edge as the next read: forward it.
  always_comb begin
    ctr_o.bc = (bi_byp_vld_q && bi_byp_idx_q == bi_idx_q) ? bi_byp_q : bi_rdata;
    ctr_o.gc = (gs_byp_vld_q && gs_byp_idx_q == gs_idx_q) ? gs_byp_q : gs_rdata;
    ctr_o.cc = (ch_byp_vld_q && ch_byp_idx_q == ch_idx_q) ? ch_byp_q : ch_rdata;
  end

  assign busy_o = clr_busy_q;

endmodule

`default_nettype wire

/* rtl/hybrid_branch_predictor_core.sv */
// Top level of the tournament (gshare + bimodal) branch predictor.
//
//   channel    dir  handshake          payload
//   branch_i   in   valid/ready        branch_pc[31:0], taken
//   result_o   out  valid/ready        predicted_taken, mispredicted,
//                                      used_gshare, mispredict_total[31:0]
//   cfg        in   cfg_we_i (no wait) cfg_wdata_i[1:0] = predictor_mode
//
// One item per cycle sustained while result_o keeps up; an item's result
// moves from the update stage into the output register. The rate is set by the
// table read-modify-write: read at accept, modify and write in the update stage,
// with a one-entry bypass per table covering back-to-back hits.
// After reset the tables are swept to their reset values across all 2^CLR_BITS
// (1024) entries with branch_i.ready low; configuration writes still land.
// A stall on result_o holds the update stage and then the input.
`default_nettype none

module hybrid_branch_predictor_core import hbp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  hbp_in_if.sink          branch_i,
  hbp_out_if.source       result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i
);

  logic [1:0]  mode_q;
  hist_t       hist_q, hist_d;

  logic        accept;
  logic        busy;

  // Update stage: the item whose counters are arriving from the RAMs.
  logic        s1_vld_q;
  logic        s1_taken_q;
  logic [1:0]  s1_mode_q;
  logic        s1_adv;

  // Output register.
  logic        out_vld_q;
  logic        out_pred_q;
  logic        out_miss_q;
  logic        out_gs_q;
  logic [31:0] miss_cnt_q, miss_cnt_d;

  rd_req_t     rd_req;
  wr_req_t     wr_req;
  ctr_rd_t     ctr;

  logic        hybrid;
  logic        bpred, gpred, use_gs, pred, miss;
  logic        chooser_move;

  // ---------------------------------------------------------------- input
  // Advance the update stage when the output register frees up.
  assign s1_adv         = s1_vld_q & (~out_vld_q | result_o.ready);
  assign branch_i.ready = ~busy & (~s1_vld_q | s1_adv);
  assign accept         = branch_i.valid & branch_i.ready;

  // Index the tables with the word address; gshare folds the history
  // into the top bits of its index.
  always_comb begin
    rd_req.en     = accept;
    rd_req.bi_idx = branch_i.branch_pc[BIMODAL_INDEX_BITS+1:2];
    rd_req.ch_idx = branch_i.branch_pc[CHOOSER_INDEX_BITS+1:2];
    rd_req.gs_idx = branch_i.branch_pc[GSHARE_INDEX_BITS+1:2]
                  ^ (gs_idx_t'(hist_q) << (GSHARE_INDEX_BITS - HIST_USED));
  end

  // Shift the newest outcome in at the top. History depends only on the
  // outcome, so it is updated at accept (except in bimodal mode) and the next item sees it at once.
  always_comb begin
    if (HIST_USED == 0) begin
      hist_d = '0;
    end else begin
      hist_d = (hist_q >> 1) | (hist_t'(branch_i.taken) << (HIST_W - 1));
    end
  end

  hbp_tables u_tables (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .wr_i   (wr_req),
    .ctr_o  (ctr),
    .busy_o (busy)
  );

  // --------------------------------------------------------- update stage
  // Mode 3 decodes as hybrid, like mode 2.
  always_comb begin
    hybrid       = (s1_mode_q != MODE_BIMODAL) && (s1_mode_q != MODE_GSHARE);
    bpred        = ctr.bc[1];
    gpred        = ctr.gc[1];
    use_gs       = (s1_mode_q == MODE_GSHARE) | (hybrid & ctr.cc[1]);
    pred         = use_gs ? gpred : bpred;
    miss         = pred ^ s1_taken_q;
    // Move the chooser only when exactly one component was right.
    chooser_move = hybrid & ((gpred == s1_taken_q) != (bpred == s1_taken_q));

    wr_req.bi_we  = s1_adv & ~use_gs;
    wr_req.gs_we  = s1_adv & use_gs;
    wr_req.ch_we  = s1_adv & chooser_move;
    wr_req.bi_ctr = sat_train(ctr.bc, s1_taken_q);
    wr_req.gs_ctr = sat_train(ctr.gc, s1_taken_q);
    wr_req.ch_ctr = sat_train(ctr.cc, gpred == s1_taken_q);

    miss_cnt_d    = miss_cnt_q + {31'd0, miss};
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HYBRID;
      hist_q     <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      miss_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept && mode_q != MODE_BIMODAL) begin
        hist_q <= hist_d;
      end
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q  <= 1'b1;
        miss_cnt_q <= miss_cnt_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: hold unless a new item moves in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_taken_q <= branch_i.taken;
      s1_mode_q  <= mode_q;
    end
    if (s1_adv) begin
      out_pred_q <= pred;
      out_miss_q <= miss;
      out_gs_q   <= use_gs;
    end
  end

  assign result_o.valid            = out_vld_q;
  assign result_o.predicted_taken  = out_pred_q;
  assign result_o.mispredicted     = out_miss_q;
  assign result_o.used_gshare      = out_gs_q;
  assign result_o.mispredict_total = miss_cnt_q;

endmodule

`default_nettype wire
